[rtl/wda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wda_pkg: shared types and constants of the weighted decimating averager
// Frame layout, queue word and config-clear bundle used by all modules.
// ----------------------------------------------------------------------------
package wda_pkg;

  localparam int unsigned CHANNELS    = 4;
  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned STAMP_BITS  = 64;
  localparam int unsigned STEP_BITS   = 11;
  localparam int unsigned MAX_STEP    = 1024;
  localparam int unsigned SUM_BITS    = 56;
  localparam int unsigned TRI_BITS    = 20;
  localparam int unsigned AVG_BITS    = 32;
  localparam int unsigned PROD_BITS   = SAMPLE_BITS + TRI_BITS + 1;
  localparam int unsigned DATA_BITS   = CHANNELS * SAMPLE_BITS + STAMP_BITS;
  localparam int unsigned ODATA_BITS  = CHANNELS * AVG_BITS + STAMP_BITS;
  localparam int unsigned ADDR_BITS   = 3;
  localparam int unsigned APB_BITS    = 32;

  localparam logic REG_STEP   = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  typedef logic [CHANNELS-1:0] chan_mask_t;

  typedef struct packed {
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] value;
    chan_mask_t                           active;
    logic [STEP_BITS-1:0]                 size;
    logic [TRI_BITS-1:0]                  weight_total;
    logic                                 close;
    logic [STAMP_BITS-1:0]                stamp;
  } item_t;

  typedef struct packed {
    logic       valid;
    chan_mask_t mask;
  } clear_t;

endpackage

[rtl/wda_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wda_front: config registers and frame classification
// Holds step, channel enable and window position; pushes one queue word
// per accepted frame while any channel is enabled, marking whether it closes the window.
// ----------------------------------------------------------------------------
module wda_front
  import wda_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_BITS-1:0]   paddr,
  input  logic [APB_BITS-1:0]    pwdata,
  output logic [APB_BITS-1:0]    prdata,
  output logic                   pready,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_BITS-1:0]   s_axis_tdata,
  input  logic [CHANNELS-1:0]    s_axis_tuser,
  input  logic                   queue_full_i,
  output logic                   push_valid_o,
  output item_t                  push_item_o,
  output clear_t                 clear_o
);

  logic [STEP_BITS-1:0]   step_q, step_d;
  chan_mask_t             enable_q, enable_d;
  logic [STEP_BITS-1:0]   pos_q, pos_d;
  logic [STEP_BITS-1:0]   step_eff;
  logic [STEP_BITS-1:0]   size;
  logic [2*STEP_BITS:0]   size_x;
  logic [2*STEP_BITS:0]   tri_prod;
  logic                   wr;
  logic                   reg_idx;
  logic                   accept;
  logic                   close;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    case (reg_idx)
      REG_STEP:   prdata = APB_BITS'(step_q);
      REG_ENABLE: prdata = APB_BITS'(enable_q);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (step_q == '0) begin
      step_eff = STEP_BITS'(1);
    end else if (step_q > STEP_BITS'(MAX_STEP)) begin
      step_eff = STEP_BITS'(MAX_STEP);
    end else begin
      step_eff = step_q;
    end
  end

  assign size     = pos_q + 1'b1;
  assign size_x   = (2*STEP_BITS+1)'(size);
  assign tri_prod = size_x * (size_x + 1'b1);
  assign close    = size >= step_eff;

  assign s_axis_tready = !queue_full_i;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign push_valid_o  = accept & (enable_q != '0);

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      push_item_o.value[c] = s_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
    end
    push_item_o.active       = s_axis_tuser & enable_q;
    push_item_o.size         = size;
    push_item_o.weight_total = tri_prod[TRI_BITS:1];
    push_item_o.close        = close;
    push_item_o.stamp        = s_axis_tdata[CHANNELS*SAMPLE_BITS +: STAMP_BITS];
  end

  assign clear_o.valid = wr & (reg_idx == REG_ENABLE);
  assign clear_o.mask  = ~pwdata[CHANNELS-1:0];

  always_comb begin
    step_d   = step_q;
    enable_d = enable_q;
    pos_d    = pos_q;
    if (push_valid_o) begin
      pos_d = close ? '0 : size;
    end
    if (wr) begin
      case (reg_idx)
        REG_STEP: begin
          step_d = pwdata[STEP_BITS-1:0];
        end
        REG_ENABLE: begin
          enable_d = pwdata[CHANNELS-1:0];
          if (pwdata[CHANNELS-1:0] == '0) begin
            pos_d = '0;
          end
        end
        default: begin
          step_d = step_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_BITS'(1);
      enable_q <= '1;
      pos_q    <= '0;
    end else begin
      step_q   <= step_d;
      enable_q <= enable_d;
      pos_q    <= pos_d;
    end
  end

endmodule

[rtl/wda_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wda_queue: short word queue between front and back
// Register-based fifo, head word presented combinationally.
// ----------------------------------------------------------------------------
module wda_queue
  import wda_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t head_o
);

  localparam int unsigned PTR_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  item_t               mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] count_q;

  assign full_o  = count_q == CNT_BITS'(DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[rtl/wda_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wda_back: weighted accumulation and window averaging
// One shared multiplier walks the channels; on window close four
// bit-serial dividers form the averages into the output register.
// ----------------------------------------------------------------------------
module wda_back
  import wda_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  item_t                 head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  input  clear_t                clear_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [ODATA_BITS-1:0] m_axis_tdata,
  output logic [CHANNELS-1:0]   m_axis_tuser
);

  localparam int unsigned CH_BITS  = $clog2(CHANNELS);
  localparam int unsigned CNT_BITS = $clog2(AVG_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DINIT,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e                       state_q;
  item_t                        item_q;
  logic [CH_BITS-1:0]           ch_q;
  logic [CNT_BITS-1:0]          cnt_q;
  logic signed [PROD_BITS-1:0]  prod_q;
  logic signed [SUM_BITS-1:0]   sum_q [CHANNELS];
  chan_mask_t                   live_q;
  logic [TRI_BITS-1:0]          rem_q [CHANNELS];
  logic [AVG_BITS-1:0]          dq_q [CHANNELS];
  chan_mask_t                   neg_q;
  logic                         out_valid_q;
  logic [ODATA_BITS-1:0]        out_data_q;
  chan_mask_t                   out_mask_q;

  logic signed [SAMPLE_BITS-1:0] cur_val;
  logic [TRI_BITS-1:0]           mult;
  logic signed [PROD_BITS-1:0]   prod_d;
  logic signed [SUM_BITS-1:0]    prod_x;
  logic [SUM_BITS-1:0]           mag [CHANNELS];
  logic [TRI_BITS:0]             rem_sh [CHANNELS];
  logic [TRI_BITS:0]             diff [CHANNELS];
  chan_mask_t                    ge;
  logic [ODATA_BITS-1:0]         out_data_d;

  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  assign cur_val = item_q.value[ch_q];
  assign mult    = live_q[ch_q] ? TRI_BITS'(item_q.size) : item_q.weight_total;
  assign prod_d  = cur_val * $signed({1'b0, mult});
  assign prod_x  = {{(SUM_BITS-PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      mag[c]    = sum_q[c][SUM_BITS-1] ? -sum_q[c] : sum_q[c];
      rem_sh[c] = {rem_q[c], dq_q[c][AVG_BITS-1]};
      diff[c]   = rem_sh[c] - {1'b0, item_q.weight_total};
      ge[c]     = rem_sh[c] >= {1'b0, item_q.weight_total};
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (item_q.active[c]) begin
        out_data_d[c*AVG_BITS +: AVG_BITS] = neg_q[c] ? -dq_q[c] : dq_q[c];
      end else begin
        out_data_d[c*AVG_BITS +: AVG_BITS] = '0;
      end
    end
    out_data_d[CHANNELS*AVG_BITS +: STAMP_BITS] = item_q.stamp;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      ch_q        <= '0;
      cnt_q       <= '0;
      prod_q      <= '0;
      live_q      <= '0;
      neg_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_mask_q  <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        sum_q[c] <= '0;
        rem_q[c] <= '0;
        dq_q[c]  <= '0;
      end
    end else begin
      if (m_axis_tready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            item_q  <= head_i;
            ch_q    <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= prod_d;
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          if (item_q.active[ch_q]) begin
            sum_q[ch_q]  <= live_q[ch_q] ? sum_q[ch_q] + prod_x : prod_x;
            live_q[ch_q] <= 1'b1;
          end
          if (ch_q == CH_BITS'(CHANNELS - 1)) begin
            state_q <= item_q.close ? ST_DINIT : ST_IDLE;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= ST_MUL;
          end
        end
        ST_DINIT: begin
          for (int c = 0; c < CHANNELS; c++) begin
            neg_q[c] <= sum_q[c][SUM_BITS-1];
            rem_q[c] <= mag[c][AVG_BITS +: TRI_BITS];
            dq_q[c]  <= mag[c][AVG_BITS-1:0];
          end
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (ge[c]) begin
              rem_q[c] <= diff[c][TRI_BITS-1:0];
            end else begin
              rem_q[c] <= rem_sh[c][TRI_BITS-1:0];
            end
            dq_q[c] <= {dq_q[c][AVG_BITS-2:0], ge[c]};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_BITS'(AVG_BITS - 1)) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= out_data_d;
            out_mask_q  <= item_q.active;
            live_q      <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
              sum_q[c] <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      // disabled channels drop their partial sums
      if (clear_i.valid) begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (clear_i.mask[c]) begin
            sum_q[c]  <= '0;
            live_q[c] <= 1'b0;
          end
        end
      end
    end
  end

endmodule

[rtl/weighted_decimating_averager_top.sv]
`timescale 1ns / 1ps
// the back end takes one frame at a time from the queue: a fetch, then a multiply and an
//   add per channel on the shared multiplier; a window-closing frame then passes divider
//   setup, the serial dividers and the output register, which waits while a result is held
// the front keeps taking frames into the queue while the back works, until the queue is full
// reset: asynchronous, active low; step 1, all channels enabled, sums and window cleared
// ----------------------------------------------------------------------------
// weighted_decimating_averager_top: linearly weighted decimating averager
// Front classifies frames, a short queue decouples it from the
// accumulate and divide back end.
// ----------------------------------------------------------------------------
module weighted_decimating_averager_top
  import wda_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [APB_BITS-1:0]   pwdata,
  output logic [APB_BITS-1:0]   prdata,
  output logic                  pready,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // chan0_value, chan1_value, chan2_value, chan3_value, stamp
  input  logic [DATA_BITS-1:0]  s_axis_tdata,
  // present_mask
  input  logic [CHANNELS-1:0]   s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // avg0, avg1, avg2, avg3, out_stamp
  output logic [ODATA_BITS-1:0] m_axis_tdata,
  // valid_mask
  output logic [CHANNELS-1:0]   m_axis_tuser
);

  logic   push_valid;
  item_t  push_item;
  logic   queue_full;
  logic   queue_empty;
  logic   pop;
  item_t  head;
  clear_t clear;

  wda_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_full_i  (queue_full),
    .push_valid_o  (push_valid),
    .push_item_o   (push_item),
    .clear_o       (clear)
  );

  wda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_item_i (push_item),
    .full_o      (queue_full),
    .pop_i       (pop),
    .empty_o     (queue_empty),
    .head_o      (head)
  );

  wda_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (queue_empty),
    .pop_o         (pop),
    .clear_i       (clear),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
